// ----- hw/rtl/ketlru_pkg.sv -----
// shared widths, codes and control/status types for the keyed entry table
package ketlru_pkg;

   // table geometry
   localparam int ENTRIES_DEFAULT = 2;
   localparam int SLOT_W          = 4;

   // field widths
   localparam int KEY_W   = 32;
   localparam int STAMP_W = 32;
   localparam int FRAME_W = 16;
   localparam int ID_W    = 8;

   // transaction kinds
   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // result status codes
   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_BAD_SLOT = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic scan_step;
      logic commit_update;
      logic commit_remove;
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic scan_last;
   } dp_status_type;

endpackage

// ----- hw/rtl/ketlru_ctrl.sv -----
// controller state machine: accept, scan the entries, commit or remove
module ketlru_ctrl import ketlru_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_kind,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_COMMIT = 4'b0100,
      ST_REMOVE = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_kind == KIND_REMOVE) ? ST_REMOVE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         ST_REMOVE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands to the datapath
   always_comb begin
      cmd.load          = (state_ff == ST_IDLE) && start;
      cmd.scan_step     = (state_ff == ST_SCAN);
      cmd.commit_update = (state_ff == ST_COMMIT);
      cmd.commit_remove = (state_ff == ST_REMOVE);
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- hw/rtl/ketlru_dpath.sv -----
// datapath: request registers, entry storage, scan trackers and result registers
module ketlru_dpath import ketlru_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   output dp_status_type      status,
   input  logic               req_kind,
   input  logic [KEY_W-1:0]   req_freq_hz,
   input  logic [FRAME_W-1:0] req_frame_word,
   input  logic [STAMP_W-1:0] req_now_ticks,
   input  logic [SLOT_W-1:0]  req_remove_slot,
   output logic               rsp_valid,
   output logic [SLOT_W-1:0]  rsp_slot,
   output logic [ID_W-1:0]    rsp_entry_id,
   output logic               rsp_hit,
   output logic               rsp_replaced,
   output logic [FRAME_W-1:0] rsp_frame_count,
   output logic               rsp_status
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = SLOT_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(ENTRIES);

   // latched request
   logic               req_kind_ff;
   logic [KEY_W-1:0]   req_key_ff;
   logic [FRAME_W-1:0] req_frame_ff;
   logic [STAMP_W-1:0] req_now_ff;
   logic [SLOT_W-1:0]  req_rslot_ff;

   // entry storage
   logic [ENTRIES-1:0] valid_ff;
   logic [KEY_W-1:0]   key_ff   [ENTRIES];
   logic [STAMP_W-1:0] stamp_ff [ENTRIES];
   logic [FRAME_W-1:0] frame_ff [ENTRIES];
   logic [ID_W-1:0]    ident_ff [ENTRIES];
   logic [ID_W-1:0]    id_cnt_ff;

   // scan trackers
   logic [IDX_W-1:0]   scan_idx_ff,   scan_idx_in;
   logic               hit_found_ff,  hit_found_in;
   logic [IDX_W-1:0]   hit_idx_ff,    hit_idx_in;
   logic [ID_W-1:0]    hit_ident_ff,  hit_ident_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff,   free_idx_in;
   logic [STAMP_W-1:0] min_stamp_ff,  min_stamp_in;
   logic [IDX_W-1:0]   min_idx_ff,    min_idx_in;

   // result registers
   logic               rsp_valid_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic [ID_W-1:0]    rsp_id_ff;
   logic               rsp_hit_ff;
   logic               rsp_replaced_ff;
   logic [FRAME_W-1:0] rsp_frame_ff;
   logic               rsp_status_ff;

   logic [IDX_W-1:0]   rd_idx;
   logic               cur_valid;
   logic [KEY_W-1:0]   cur_key;
   logic [STAMP_W-1:0] cur_stamp;
   logic [FRAME_W-1:0] cur_frame;
   logic [ID_W-1:0]    cur_ident;
   logic [IDX_W-1:0]   sel_idx;
   logic [ID_W-1:0]    new_ident;
   logic               rm_in_range;
   logic               rm_ok;

   // single read port: the scan slot, or the slot named by a remove
   assign rd_idx    = (req_kind_ff == KIND_REMOVE) ? req_rslot_ff[IDX_W-1:0] : scan_idx_ff;
   assign cur_valid = valid_ff[rd_idx];
   assign cur_key   = key_ff[rd_idx];
   assign cur_stamp = stamp_ff[rd_idx];
   assign cur_frame = frame_ff[rd_idx];
   assign cur_ident = ident_ff[rd_idx];

   assign status.scan_last = (scan_idx_ff == LAST_IDX);

   // remove qualification
   assign rm_in_range = ({1'b0, req_rslot_ff} < ENTRIES_CNT);
   assign rm_ok       = rm_in_range && cur_valid;

   // slot choice at commit: hit, then lowest free, then oldest
   assign sel_idx   = hit_found_ff  ? hit_idx_ff  :
                      free_found_ff ? free_idx_ff : min_idx_ff;
   assign new_ident = hit_found_ff ? hit_ident_ff : id_cnt_ff;

   // scan tracker next values, one entry per step
   always_comb begin
      scan_idx_in   = scan_idx_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_ident_in  = hit_ident_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      min_stamp_in  = min_stamp_ff;
      min_idx_in    = min_idx_ff;
      if (cmd.load) begin
         scan_idx_in   = '0;
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
         min_stamp_in  = '1;
         min_idx_in    = '0;
      end else if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
         if (!hit_found_ff && cur_valid && (cur_key == req_key_ff)) begin
            hit_found_in = 1'b1;
            hit_idx_in   = scan_idx_ff;
            hit_ident_in = cur_ident;
         end
         if (!free_found_ff && !cur_valid) begin
            free_found_in = 1'b1;
            free_idx_in   = scan_idx_ff;
         end
         // strict compare keeps the lowest slot on equal stamps
         if (cur_valid && (cur_stamp < min_stamp_ff)) begin
            min_stamp_in = cur_stamp;
            min_idx_in   = scan_idx_ff;
         end
      end
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         id_cnt_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         scan_idx_ff   <= '0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         req_kind_ff   <= KIND_UPDATE;
      end else begin
         rsp_valid_ff  <= cmd.commit_update || cmd.commit_remove;
         scan_idx_ff   <= scan_idx_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         if (cmd.load) begin
            req_kind_ff <= req_kind;
         end
         if (cmd.commit_update) begin
            valid_ff[sel_idx] <= 1'b1;
            if (!hit_found_ff) begin
               id_cnt_ff <= id_cnt_ff + ID_W'(1);
            end
         end
         if (cmd.commit_remove && rm_ok) begin
            valid_ff[rd_idx] <= 1'b0;
         end
      end
   end

   // payload: request capture, trackers and entry fields
   always_ff @(posedge clock) begin
      hit_idx_ff   <= hit_idx_in;
      hit_ident_ff <= hit_ident_in;
      free_idx_ff  <= free_idx_in;
      min_stamp_ff <= min_stamp_in;
      min_idx_ff   <= min_idx_in;
      if (cmd.load) begin
         req_key_ff   <= req_freq_hz;
         req_frame_ff <= {req_frame_word[7:0], req_frame_word[15:8]};
         req_now_ff   <= req_now_ticks;
         req_rslot_ff <= req_remove_slot;
      end
      if (cmd.commit_update) begin
         key_ff[sel_idx]   <= req_key_ff;
         stamp_ff[sel_idx] <= req_now_ff;
         frame_ff[sel_idx] <= req_frame_ff;
         ident_ff[sel_idx] <= new_ident;
      end
   end

   // result capture
   always_ff @(posedge clock) begin
      if (cmd.commit_update) begin
         rsp_slot_ff     <= SLOT_W'(sel_idx);
         rsp_id_ff       <= new_ident;
         rsp_hit_ff      <= hit_found_ff;
         rsp_replaced_ff <= !hit_found_ff && !free_found_ff;
         rsp_frame_ff    <= req_frame_ff;
         rsp_status_ff   <= STATUS_DONE;
      end else if (cmd.commit_remove) begin
         rsp_slot_ff     <= req_rslot_ff;
         rsp_id_ff       <= rm_ok ? cur_ident : '0;
         rsp_hit_ff      <= 1'b0;
         rsp_replaced_ff <= 1'b0;
         rsp_frame_ff    <= rm_ok ? cur_frame : '0;
         rsp_status_ff   <= rm_ok ? STATUS_DONE : STATUS_BAD_SLOT;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_entry_id    = rsp_id_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_replaced    = rsp_replaced_ff;
   assign rsp_frame_count = rsp_frame_ff;
   assign rsp_status      = rsp_status_ff;

   // every commit is followed by exactly one result strobe
   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit_update || cmd.commit_remove) |=> rsp_valid_ff)
      else $error("commit without result strobe");

   // eviction only when every slot is occupied
   a_evict_only_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit_update && !hit_found_ff && !free_found_ff) |-> (&valid_ff))
      else $error("eviction while a slot is free");

   // a result is never both a hit and a replacement
   a_hit_not_repl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_replaced_ff))
      else $error("hit and replaced both set");

   // identifier counter moves only on an allocating commit
   a_id_hold: assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit_update && !hit_found_ff) |=> $stable(id_cnt_ff))
      else $error("identifier counter moved without allocation");

endmodule

// ----- hw/rtl/keyed_entry_table_lru_replace.sv -----
// top level of the keyed entry table with least-recently-updated replacement
//
//   channel   ports                               handshake
//   request   req_kind .. req_remove_slot         start high while busy low
//   result    rsp_slot .. rsp_status              rsp_valid, one cycle, no stall
//
// an update scans one entry per cycle through the single table read port,
// with busy high through the scan and commit states, so a new update waits until
// the commit; a remove keeps busy high through the remove state. the result
// strobe rises in the cycle busy falls; a new transaction may be accepted at
// the end of that cycle. reset clears the valid bits, identifier counter and
// controller at once, with no clearing pass. the receiver cannot stall.
module keyed_entry_table_lru_replace import ketlru_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_kind,
   input  logic [KEY_W-1:0]   req_freq_hz,
   input  logic [FRAME_W-1:0] req_frame_word,
   input  logic [STAMP_W-1:0] req_now_ticks,
   input  logic [SLOT_W-1:0]  req_remove_slot,
   output logic               rsp_valid,
   output logic [SLOT_W-1:0]  rsp_slot,
   output logic [ID_W-1:0]    rsp_entry_id,
   output logic               rsp_hit,
   output logic               rsp_replaced,
   output logic [FRAME_W-1:0] rsp_frame_count,
   output logic               rsp_status
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer
   ketlru_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // table and result registers
   ketlru_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_freq_hz     (req_freq_hz),
      .req_frame_word  (req_frame_word),
      .req_now_ticks   (req_now_ticks),
      .req_remove_slot (req_remove_slot),
      .rsp_valid       (rsp_valid),
      .rsp_slot        (rsp_slot),
      .rsp_entry_id    (rsp_entry_id),
      .rsp_hit         (rsp_hit),
      .rsp_replaced    (rsp_replaced),
      .rsp_frame_count (rsp_frame_count),
      .rsp_status      (rsp_status)
   );

endmodule
